FILE: rtl/gwawb_pkg.sv
// Shared widths, register indexes and constants for the gray-world AWB gain block.
`default_nettype none
package gwawb_pkg;
  localparam int SUM_W = 40;
  localparam int CNT_W = 32;
  localparam int LVL_W = 8;
  localparam int GAIN_W = 16;
  localparam int STORE_W = GAIN_W + 1;
  localparam int QUOT_W = GAIN_W;
  localparam int SPEED_W = 9;
  localparam int SPEED_FRAC = 8;
  localparam int ACC_W = STORE_W + SPEED_W;
  localparam int GAIN_FRAC_BITS_DEF = 12;
  localparam int MAX_GAIN_INT = 4;

  localparam logic [SPEED_W-1:0] SPEED_MIN = 9'd3;
  localparam logic [SPEED_W-1:0] SPEED_ONE = 9'd256;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/gwawb_ifs.sv
// Valid/ready channel interfaces: frame statistics in, gains out, register writes.
`default_nettype none
interface gwawb_stats_if;
  import gwawb_pkg::*;
  logic valid;
  logic ready;
  logic stats_valid;
  logic [SUM_W-1:0] sum_red;
  logic [SUM_W-1:0] sum_green;
  logic [SUM_W-1:0] sum_blue;
  logic [CNT_W-1:0] pixel_count;
  logic [LVL_W-1:0] black_level;
  modport source (output valid, stats_valid, sum_red, sum_green, sum_blue, pixel_count,
                  black_level, input ready);
  modport sink (input valid, stats_valid, sum_red, sum_green, sum_blue, pixel_count,
                black_level, output ready);
endinterface

interface gwawb_gains_if;
  import gwawb_pkg::*;
  logic valid;
  logic ready;
  logic [GAIN_W-1:0] gain_red;
  logic [GAIN_W-1:0] gain_blue;
  modport source (output valid, gain_red, gain_blue, input ready);
  modport sink (input valid, gain_red, gain_blue, output ready);
endinterface

interface gwawb_cfg_if;
  import gwawb_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/gray_world_awb_gains.sv
// Gray-world auto white balance gains: top level with sequencer, registers and gain stores.
//
// One item on the stats channel carries a frame's red, green and blue sums, pixel count,
// black level and a stats_valid flag. Each item yields exactly one item on the gains
// channel: the smoothed red and blue gains (unsigned, GAIN_FRAC_BITS fraction bits).
// Registers max_gain_red (0), max_gain_blue (1) and smoothing_speed (2) are written on
// the cfg channel, which is always ready; write them only while no item is in flight.
// Each valid item passes the serial offset multiply, the two serial divisions (red, then
// blue) and the serial filter, whose red and blue lanes run side by side; a division
// whose quotient overflows 16 bits skips its serial steps. An item with stats_valid low
// goes straight to the output state and returns the held gains. The next item is accepted
// the cycle after a result is loaded into the output register, also while that result
// still waits on a stalled receiver; its own result then waits for that register.
// Reset sets both gains to 1.0, the maxima to 4.0 (saturated to the 16-bit range) and
// the speed to 1.0; no item is pending after reset.
`default_nettype none
module gray_world_awb_gains #(
  parameter int GAIN_FRAC_BITS = gwawb_pkg::GAIN_FRAC_BITS_DEF
) (
  input wire           clk,
  input wire           rst,
  gwawb_stats_if.sink  stats,
  gwawb_gains_if.source gains,
  gwawb_cfg_if.sink    cfg
);
  import gwawb_pkg::*;

  localparam logic [STORE_W-1:0] GAIN_ONE = STORE_W'(1) << GAIN_FRAC_BITS;
  localparam int MAX_RAW = MAX_GAIN_INT << GAIN_FRAC_BITS;
  localparam int GAIN_TOP = (1 << GAIN_W) - 1;
  localparam logic [GAIN_W-1:0] MAX_DEF = GAIN_W'((MAX_RAW > GAIN_TOP) ? GAIN_TOP : MAX_RAW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_REM = 3'd2;
  localparam logic [2:0] S_DIVR = 3'd3;
  localparam logic [2:0] S_DIVB = 3'd4;
  localparam logic [2:0] S_SMOOTH = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic go;
  logic accept;
  logic out_load;

  logic [GAIN_W-1:0] max_red;
  logic [GAIN_W-1:0] max_blue;
  logic [SPEED_W-1:0] speed;

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [CNT_W-1:0] count;
  logic [LVL_W-1:0] level;
  logic [SUM_W-1:0] s_r;
  logic [SUM_W-1:0] s_g;
  logic [SUM_W-1:0] s_b;
  logic [GAIN_W-1:0] raw_red;
  logic [GAIN_W-1:0] raw_blue;
  logic [STORE_W-1:0] red_store;
  logic [STORE_W-1:0] blue_store;
  logic out_valid;
  logic [GAIN_W-1:0] out_red;
  logic [GAIN_W-1:0] out_blue;

  logic mul_done;
  logic [SUM_W-1:0] offset;
  logic div_done;
  logic [SUM_W-1:0] div_den;
  logic [GAIN_W-1:0] div_max;
  logic [GAIN_W-1:0] div_raw;
  logic sm_done;
  logic sm_done_b;
  logic [GAIN_W-1:0] sm_red;
  logic [GAIN_W-1:0] sm_blue;

  assign stats.ready = (state == S_IDLE);
  assign accept = stats.valid && stats.ready;
  assign cfg.ready = 1'b1;
  assign gains.valid = out_valid;
  assign gains.gain_red = out_red;
  assign gains.gain_blue = out_blue;
  assign out_load = (state == S_OUT) && (!out_valid || gains.ready);

  assign div_den = (state == S_DIVB) ? s_b : s_r;
  assign div_max = (state == S_DIVB) ? max_blue : max_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_red <= MAX_DEF;
      max_blue <= MAX_DEF;
      speed <= SPEED_ONE;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MAX_RED: max_red <= cfg.data[GAIN_W-1:0];
        CFG_MAX_BLUE: max_blue <= cfg.data[GAIN_W-1:0];
        CFG_SPEED: speed <= cfg.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = stats.stats_valid ? S_MUL : S_OUT;
      S_MUL: if (mul_done) state_next = S_REM;
      S_REM: state_next = S_DIVR;
      S_DIVR: if (div_done) state_next = S_DIVB;
      S_DIVB: if (div_done) state_next = S_SMOOTH;
      S_SMOOTH: if (sm_done) state_next = S_OUT;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go <= 1'b0;
      out_valid <= 1'b0;
      red_store <= GAIN_ONE;
      blue_store <= GAIN_ONE;
    end else begin
      state <= state_next;
      go <= (state_next != state) && (state_next == S_MUL || state_next == S_DIVR
            || state_next == S_DIVB || state_next == S_SMOOTH);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (gains.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_SMOOTH && sm_done) begin
        red_store <= STORE_W'(sm_red);
      end
      if (state == S_SMOOTH && sm_done_b) begin
        blue_store <= STORE_W'(sm_blue);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= stats.sum_red;
      sum_g <= stats.sum_green;
      sum_b <= stats.sum_blue;
      count <= stats.pixel_count;
      level <= stats.black_level;
    end
    // a sum at or below the black offset counts as 1
    if (state == S_REM) begin
      s_r <= (sum_r > offset) ? sum_r - offset : SUM_W'(1);
      s_g <= (sum_g > offset) ? sum_g - offset : SUM_W'(1);
      s_b <= (sum_b > offset) ? sum_b - offset : SUM_W'(1);
    end
    if (state == S_DIVR && div_done) begin
      raw_red <= div_raw;
    end
    if (state == S_DIVB && div_done) begin
      raw_blue <= div_raw;
    end
    if (out_load) begin
      out_red <= red_store[GAIN_W-1:0];
      out_blue <= blue_store[GAIN_W-1:0];
    end
  end

  gwawb_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (go && state == S_MUL),
    .count   (count),
    .level   (level),
    .done    (mul_done),
    .product (offset)
  );

  gwawb_div #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (go && (state == S_DIVR || state == S_DIVB)),
    .green    (s_g),
    .den      (div_den),
    .max_gain (div_max),
    .done     (div_done),
    .raw      (div_raw)
  );

  gwawb_smooth u_smooth_red (
    .clk   (clk),
    .rst   (rst),
    .start (go && state == S_SMOOTH),
    .old   (red_store),
    .raw   (raw_red),
    .speed (speed),
    .done  (sm_done),
    .gain  (sm_red)
  );

  gwawb_smooth u_smooth_blue (
    .clk   (clk),
    .rst   (rst),
    .start (go && state == S_SMOOTH),
    .old   (blue_store),
    .raw   (raw_blue),
    .speed (speed),
    .done  (sm_done_b),
    .gain  (sm_blue)
  );

  a_invalid_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && !stats.stats_valid) |=> ($stable(red_store) && $stable(blue_store)))
    else $error("gain store changed for an item with invalid stats");

  a_div_in_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVR || state == S_DIVB))
    else $error("divider finished outside a division phase");

  a_store_on_filter: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (red_store != $past(red_store) || blue_store != $past(blue_store)))
    |-> $past(sm_done))
    else $error("gain store changed without a filter result");

  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    sm_done == sm_done_b)
    else $error("red and blue filter lanes out of step");
endmodule
`default_nettype wire

FILE: rtl/gwawb_mul.sv
// Bit-serial black offset multiplier: pixel count times black level, one level bit a cycle.
`default_nettype none
module gwawb_mul (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire [gwawb_pkg::CNT_W-1:0]  count,
  input  wire [gwawb_pkg::LVL_W-1:0]  level,
  output logic                        done,
  output logic [gwawb_pkg::SUM_W-1:0] product
);
  import gwawb_pkg::*;

  localparam int STEP_W = $clog2(LVL_W + 1);

  logic busy;
  logic [STEP_W-1:0] steps;
  logic [LVL_W-1:0] lvl_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(LVL_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      lvl_sh <= level;
    end else if (busy) begin
      product <= {product[SUM_W-2:0], 1'b0} + (lvl_sh[LVL_W-1] ? SUM_W'(count) : '0);
      lvl_sh <= {lvl_sh[LVL_W-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gwawb_div.sv
// Radix-2 restoring divider for one raw gain, one quotient bit a cycle, capped at the maximum.
`default_nettype none
module gwawb_div #(
  parameter int GAIN_FRAC_BITS = gwawb_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [gwawb_pkg::SUM_W-1:0]   green,
  input  wire [gwawb_pkg::SUM_W-1:0]   den,
  input  wire [gwawb_pkg::GAIN_W-1:0]  max_gain,
  output logic                         done,
  output logic [gwawb_pkg::GAIN_W-1:0] raw
);
  import gwawb_pkg::*;

  localparam int NUM_W = SUM_W + QUOT_W;
  localparam int STEP_W = $clog2(QUOT_W);

  logic busy;
  logic sat;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0] num_ext;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [QUOT_W-1:0] quot;
  logic ovf;
  logic ge;

  assign num_ext = NUM_W'(green) << GAIN_FRAC_BITS;
  // quotient would not fit in QUOT_W bits: it is above any maximum
  assign ovf = num_ext >= {den, {QUOT_W{1'b0}}};
  assign ge = rem >= dsh;
  assign raw = (sat || (quot >= max_gain)) ? max_gain : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !ovf;
        done <= ovf;
        step <= STEP_W'(QUOT_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat <= ovf;
      rem <= num_ext;
      dsh <= NUM_W'(den) << (QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/gwawb_smooth.sv
// Bit-serial exponential filter: old*(1-a) + raw*a, rounded, one speed bit a cycle.
`default_nettype none
module gwawb_smooth (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  input  wire [gwawb_pkg::STORE_W-1:0]  old,
  input  wire [gwawb_pkg::GAIN_W-1:0]   raw,
  input  wire [gwawb_pkg::SPEED_W-1:0]  speed,
  output logic                          done,
  output logic [gwawb_pkg::GAIN_W-1:0]  gain
);
  import gwawb_pkg::*;

  localparam int STEP_W = $clog2(SPEED_W + 1);

  logic busy;
  logic [STEP_W-1:0] steps;
  logic [SPEED_W-1:0] a_cl;
  logic [SPEED_W-1:0] b_w;
  logic [SPEED_W-1:0] a_sh;
  logic [SPEED_W-1:0] b_sh;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rounded;

  always_comb begin
    if (speed < SPEED_MIN) begin
      a_cl = SPEED_MIN;
    end else if (speed > SPEED_ONE) begin
      a_cl = SPEED_ONE;
    end else begin
      a_cl = speed;
    end
    b_w = SPEED_ONE - a_cl;
  end

  assign rounded = acc + ROUND_HALF;
  assign gain = rounded[SPEED_FRAC +: GAIN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(SPEED_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      a_sh <= a_cl;
      b_sh <= b_w;
    end else if (busy) begin
      acc <= {acc[ACC_W-2:0], 1'b0}
             + (a_sh[SPEED_W-1] ? ACC_W'(raw) : '0)
             + (b_sh[SPEED_W-1] ? ACC_W'(old) : '0);
      a_sh <= {a_sh[SPEED_W-2:0], 1'b0};
      b_sh <= {b_sh[SPEED_W-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

FILE: bench/gray_world_awb_gains_tb.sv
// Self-checking bench for gray_world_awb_gains: directed frame table, then randomized phases.
`timescale 1ns / 100ps
module gray_world_awb_gains_tb;
  import gwawb_pkg::*;

  localparam int FRAC = GAIN_FRAC_BITS_DEF;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC);
  localparam int MAX_RAW = (1 << FRAC) * MAX_GAIN_INT;
  localparam logic [GAIN_W-1:0] MAX_DEF = MAX_RAW > 65535 ? 16'hFFFF : GAIN_W'(MAX_RAW);
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam logic [SUM_W-1:0] SUM_ALL = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ALL = {CNT_W{1'b1}};
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AFTER = 120;
  localparam int PHASES = 10;
  localparam int PHASE_FRAMES = 80;

  typedef struct packed {
    logic ok;
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
    logic [LVL_W-1:0] black;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  typedef struct packed {
    logic [GAIN_W-1:0] red;
    logic [GAIN_W-1:0] blue;
  } gain_pair_t;

  typedef struct {
    bit is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    frame_t f;
    bit typed;
    logic [GAIN_W-1:0] er;
    logic [GAIN_W-1:0] eb;
  } plan_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

  logic clk;
  logic rst;

  gwawb_stats_if stats_ch();
  gwawb_gains_if gains_ch();
  gwawb_cfg_if cfg_ch();

  gray_world_awb_gains i_dut (
    .clk(clk),
    .rst(rst),
    .stats(stats_ch),
    .gains(gains_ch),
    .cfg(cfg_ch)
  );

  logic [GAIN_W-1:0] model_red = GAIN_ONE;
  logic [GAIN_W-1:0] model_blue = GAIN_ONE;
  logic [GAIN_W-1:0] model_max_red = MAX_DEF;
  logic [GAIN_W-1:0] model_max_blue = MAX_DEF;
  logic [SPEED_W-1:0] model_speed = SPEED_ONE;

  gain_pair_t gains_due[$];
  plan_row_t directed_plan[$];
  int errors = 0;
  int gains_seen = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] above_black(input logic [63:0] s, input logic [63:0] off);
    logic [63:0] fl;
    fl = off + 64'd1;
    return (s < fl ? fl : s) - off;
  endfunction

  function automatic logic [GAIN_W-1:0] capped_ratio(input logic [63:0] g, input logic [63:0] c,
                                                     input logic [GAIN_W-1:0] mx);
    logic [63:0] num;
    num = g << FRAC;
    if (c * 64'(mx) <= num) return mx;
    return GAIN_W'(num / c);
  endfunction

  function automatic logic [GAIN_W-1:0] smooth_gain(input logic [GAIN_W-1:0] old,
                                                    input logic [GAIN_W-1:0] raw,
                                                    input logic [SPEED_W-1:0] a);
    logic [63:0] v;
    v = 64'(old) * 64'(SPEED_ONE - a) + 64'(raw) * 64'(a) + 64'd128;
    return v[SPEED_FRAC +: GAIN_W];
  endfunction

  task automatic advance_gains(input frame_t f, output gain_pair_t p);
    logic [63:0] off, r, g, b;
    logic [SPEED_W-1:0] a;
    if (f.ok) begin
      off = 64'(f.count) * 64'(f.black);
      r = above_black(64'(f.red), off);
      g = above_black(64'(f.green), off);
      b = above_black(64'(f.blue), off);
      a = model_speed;
      if (a < SPEED_MIN) a = SPEED_MIN;
      if (a > SPEED_ONE) a = SPEED_ONE;
      model_red = smooth_gain(model_red, capped_ratio(g, r, model_max_red), a);
      model_blue = smooth_gain(model_blue, capped_ratio(g, b, model_max_blue), a);
    end
    p.red = model_red;
    p.blue = model_blue;
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    logic [63:0] off, net;
    int pick;
    pick = $urandom_range(0, 99);
    f = FRAME_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    f.ok = 1'b1;
    if (pick < 10) begin
      f.ok = 1'b0;
    end else if (pick >= 25) begin
      f.count = $urandom_range(0, 1 << 20);
      f.black = LVL_W'($urandom_range(0, 255));
      off = 64'(f.count) * 64'(f.black);
      if (pick < 85) begin
        net = ({$urandom, $urandom} >> $urandom_range(28, 63)) + 64'd1;
        f.green = SUM_W'(off + net);
        f.red = SUM_W'(off + net * $urandom_range(16, 1100) / 256);
        f.blue = SUM_W'(off + net * $urandom_range(16, 1100) / 256);
      end else begin
        f.red = SUM_W'(off + $urandom_range(0, 16) - 8);
        f.green = SUM_W'(off + $urandom_range(0, 16) - 8);
        f.blue = SUM_W'(off + $urandom_range(0, 16) - 8);
      end
    end
    return f;
  endfunction

  task automatic row_frame(input logic ok, input logic [SUM_W-1:0] r, input logic [SUM_W-1:0] g,
                           input logic [SUM_W-1:0] b, input logic [CNT_W-1:0] pc,
                           input logic [LVL_W-1:0] bl, input bit typed = 0,
                           input logic [GAIN_W-1:0] er = '0, input logic [GAIN_W-1:0] eb = '0);
    plan_row_t row;
    row = '{default: '0};
    row.f = {ok, r, g, b, pc, bl};
    row.typed = typed;
    row.er = er;
    row.eb = eb;
    directed_plan.push_back(row);
  endtask

  task automatic row_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.idx = idx;
    row.data = data;
    directed_plan.push_back(row);
  endtask

  task automatic offer_frame(input frame_t f, input bit typed = 0,
                             input logic [GAIN_W-1:0] er = '0, input logic [GAIN_W-1:0] eb = '0);
    gain_pair_t p;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
      if (gap > 0) begin
        @(negedge clk);
        stats_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    stats_ch.valid = 1'b1;
    stats_ch.stats_valid = f.ok;
    stats_ch.sum_red = f.red;
    stats_ch.sum_green = f.green;
    stats_ch.sum_blue = f.blue;
    stats_ch.pixel_count = f.count;
    stats_ch.black_level = f.black;
    do @(posedge clk); while (!stats_ch.ready);
    advance_gains(f, p);
    if (typed) begin
      p.red = er;
      p.blue = eb;
    end
    gains_due.push_back(p);
  endtask

  task automatic drain();
    @(negedge clk);
    stats_ch.valid = 1'b0;
    while (gains_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_MAX_RED: model_max_red = data;
      CFG_MAX_BLUE: model_max_blue = data;
      CFG_SPEED: model_speed = data[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] set_red, set_blue, set_speed;
    rst = 1'b1;
    stats_ch.valid = 1'b0;
    stats_ch.stats_valid = 1'b0;
    stats_ch.sum_red = '0;
    stats_ch.sum_green = '0;
    stats_ch.sum_blue = '0;
    stats_ch.pixel_count = '0;
    stats_ch.black_level = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_RED;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    row_frame(0, 0, 0, 0, 0, 0, 1, GAIN_ONE, GAIN_ONE);
    row_frame(1, 1000, 1000, 1000, 0, 0, 1, GAIN_ONE, GAIN_ONE);
    row_frame(1, 1000, 8000, 1000, 0, 0, 1, MAX_DEF, MAX_DEF);
    row_frame(1, SUM_ALL, SUM_ALL, SUM_ALL, CNT_ALL, 8'hFF, 1, GAIN_ONE, GAIN_ONE);
    row_frame(1, 0, 0, 0, 0, 0, 1, GAIN_ONE, GAIN_ONE);
    row_frame(1, SUM_ALL, 0, SUM_ALL, 0, 0, 1, 16'd0, 16'd0);
    // invalid stats hold the zero gains
    row_frame(0, SUM_ALL, SUM_ALL, SUM_ALL, CNT_ALL, 8'hFF, 1, 16'd0, 16'd0);
    row_frame(1, 1, SUM_ALL, 2, 0, 0, 1, MAX_DEF, MAX_DEF);
    row_frame(1, 3000, 4000, 5000, 0, 0);
    row_frame(1, 65000, 66000, 64500, 1000, 64);
    // red sum exactly at the black offset
    row_frame(1, 64000, 64100, 70000, 1000, 64);
    row_reg(CFG_MAX_RED, 16'd0);
    row_reg(CFG_MAX_BLUE, 16'hFFFF);
    row_reg(CFG_SPEED, 16'd0);
    row_frame(1, 100, 100, 100, 0, 0);
    row_reg(CFG_SPEED, 16'd2);
    row_frame(1, 100, 250, 40, 0, 0);
    row_reg(CFG_SPEED, 16'hFFFF);
    row_reg(CFG_NONE, 16'd1);
    row_frame(1, 1, 100, 1, 0, 0, 1, 16'd0, 16'hFFFF);
    row_reg(CFG_MAX_RED, 16'd1);
    row_reg(CFG_MAX_BLUE, 16'd1);
    row_frame(1, 7, 7, 7, 0, 0, 1, 16'd1, 16'd1);
    row_reg(CFG_SPEED, 16'd300);
    row_frame(1, 9, 9, 9, 0, 0, 1, 16'd1, 16'd1);
    row_reg(CFG_SPEED, 16'd128);
    row_reg(CFG_MAX_RED, MAX_DEF);
    row_reg(CFG_MAX_BLUE, MAX_DEF);
    row_frame(1, 500, 900, 300, 0, 0);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_reg) begin
        drain();
        write_reg(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        offer_frame(directed_plan[i].f, directed_plan[i].typed, directed_plan[i].er,
                    directed_plan[i].eb);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          set_red = 16'hFFFF; set_blue = 16'hFFFF; set_speed = CFG_DATA_W'(SPEED_ONE);
        end
        1: begin
          set_red = 16'd1; set_blue = 16'd1; set_speed = CFG_DATA_W'(SPEED_MIN);
        end
        2: begin set_red = 16'd0; set_blue = MAX_DEF; set_speed = 16'd0; end
        3: begin set_red = MAX_DEF; set_blue = 16'd8192; set_speed = 16'hFFFF; end
        4: begin set_red = GAIN_ONE; set_blue = 16'd20000; set_speed = 16'd1; end
        default: begin
          set_red = CFG_DATA_W'($urandom_range(0, 65535));
          set_blue = CFG_DATA_W'($urandom_range(0, 65535));
          set_speed = CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 300));
        end
      endcase
      drain();
      write_reg(CFG_MAX_RED, set_red);
      write_reg(CFG_MAX_BLUE, set_blue);
      write_reg(CFG_SPEED, set_speed);
      for (int n = 0; n < PHASE_FRAMES; n++) offer_frame(random_frame());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("gray_world_awb_gains verification clean");
    end else begin
      $display("gray_world_awb_gains verification failed");
    end
    $finish;
  end

  // result sink: changing stall patterns plus one long hold-off
  initial begin
    rx_mode_e mode;
    int mode_left;
    int stall_left;
    bit held;
    mode = RX_OPEN;
    mode_left = 0;
    stall_left = 0;
    held = 0;
    gains_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && gains_seen >= HOLD_AFTER) begin
        held = 1;
        gains_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        RX_OPEN: gains_ch.ready = 1'b1;
        RX_COIN: gains_ch.ready = ($urandom_range(0, 1) == 1);
        RX_SPARSE: gains_ch.ready = ($urandom_range(0, 7) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            gains_ch.ready = 1'b0;
          end else begin
            gains_ch.ready = 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
          end
        end
      endcase
      @(negedge clk);
    end
  end

  gain_pair_t due;

  always @(posedge clk) begin
    if (!rst && gains_ch.valid && gains_ch.ready) begin
      gains_seen++;
      if (gains_due.size() == 0) begin
        $display("%0t: unexpected gains red=%0d blue=%0d", $time, gains_ch.gain_red,
                 gains_ch.gain_blue);
        errors++;
      end else begin
        due = gains_due.pop_front();
        if (gains_ch.gain_red !== due.red) begin
          $display("%0t: gain_red expected %0d actual %0d", $time, due.red, gains_ch.gain_red);
          errors++;
        end
        if (gains_ch.gain_blue !== due.blue) begin
          $display("%0t: gain_blue expected %0d actual %0d", $time, due.blue,
                   gains_ch.gain_blue);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("gray_world_awb_gains verification failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/gwawb_pkg.sv
rtl/gwawb_ifs.sv
rtl/gwawb_mul.sv
rtl/gwawb_div.sv
rtl/gwawb_smooth.sv
rtl/gray_world_awb_gains.sv
bench/gray_world_awb_gains_tb.sv
